>>> hw/rtl/lcff_pkg.sv
package lcff_pkg;

  // Sizes of the stores and fields
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned CT_DEPTH = 256;
  localparam int unsigned CT_AW    = $clog2(CT_DEPTH);
  localparam int unsigned IDX_W    = CT_AW + 1;
  localparam int unsigned C_DEPTH  = 64;
  localparam int unsigned C_AW     = $clog2(C_DEPTH);
  localparam int unsigned COCC_W   = C_AW + 1;
  localparam int unsigned FORG_W   = 7;
  localparam int unsigned LEFT_W   = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FREQ_FLOOR   = 3'd0,
    CFG_FORGIVE_LIM  = 3'd1,
    CFG_FORGIVE_UNL  = 3'd2,
    CFG_TABLE_LIMIT  = 3'd3,
    CFG_CAPACITY     = 3'd4
  } lcff_cfg_e;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_IDX_INC,
    OP_CT_READ,
    OP_CT_FOUND,
    OP_CT_DROP,
    OP_CT_NEW,
    OP_CT_SH_READ,
    OP_CT_SH_WRITE,
    OP_CT_HEAD,
    OP_C_READ,
    OP_C_HIT,
    OP_C_INS_SETUP,
    OP_C_SH_READ,
    OP_C_SH_WRITE,
    OP_C_HEAD_KEY,
    OP_C_HEAD_INS,
    OP_C_HEAD_TAIL,
    OP_LEFT_INIT,
    OP_C_TAIL_READ,
    OP_C_TAIL_GET,
    OP_T_ABSENT,
    OP_T_FOUND,
    OP_FORGIVE,
    OP_EVICT,
    OP_EMIT
  } lcff_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CT_SRD,
    S_CT_SCHK,
    S_CT_DROP,
    S_CT_SHR,
    S_CT_SHW,
    S_C_SRD,
    S_C_SCHK,
    S_C_EV,
    S_C_SHR,
    S_C_SHW,
    S_C_TRD,
    S_C_TGET,
    S_T_SRD,
    S_T_SCHK,
    S_C_DEC,
    S_DONE
  } lcff_state_e;

  typedef enum logic [1:0] {
    RET_HIT,
    RET_INS,
    RET_TAIL
  } lcff_ret_e;

  typedef struct packed {
    lcff_op_e op;
  } lcff_cmd_t;

  typedef struct packed {
    logic idx_zero;
    logic idx_at_ct_occ;
    logic idx_at_c_occ;
    logic ct_match_key;
    logic ct_match_tail;
    logic c_match;
    logic ct_full;
    logic c_full;
    logic forgive;
    logic out_free;
  } lcff_sts_t;

endpackage

>>> hw/rtl/lcff_if.sv
// Request channel: one key per item
interface lcff_req_if;
  logic        valid;
  logic        ready;
  logic [63:0] request_key;

  modport source (output valid, output request_key, input ready);
  modport sink (input valid, input request_key, output ready);
endinterface

// Result channel: one result per request
interface lcff_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        evicted_valid;
  logic [63:0] evicted_key;
  logic [6:0]  forgiven_count;
  logic [15:0] access_count;
  logic        count_entry_dropped;

  modport source (output valid, output hit, output evicted_valid, output evicted_key,
                  output forgiven_count, output access_count,
                  output count_entry_dropped, input ready);
  modport sink (input valid, input hit, input evicted_valid, input evicted_key,
                input forgiven_count, input access_count,
                input count_entry_dropped, output ready);
endinterface

>>> hw/rtl/lcff_ram.sv
module lcff_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lcff_ctrl.sv
module lcff_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lcff_pkg::lcff_sts_t sts_i,
  output lcff_pkg::lcff_cmd_t cmd_o
);
  import lcff_pkg::*;

  lcff_state_e state_q, state_d;
  lcff_ret_e   ret_q, ret_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_HIT;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_CT_SRD;
      S_CT_SRD:  state_d = sts_i.idx_at_ct_occ ? S_CT_DROP : S_CT_SCHK;
      S_CT_SCHK: state_d = sts_i.ct_match_key ? S_CT_SHR : S_CT_SRD;
      S_CT_DROP: if (!sts_i.ct_full) state_d = S_CT_SHR;
      S_CT_SHR:  state_d = sts_i.idx_zero ? S_C_SRD : S_CT_SHW;
      S_CT_SHW:  state_d = S_CT_SHR;
      S_C_SRD:   state_d = sts_i.idx_at_c_occ ? S_C_EV : S_C_SCHK;
      S_C_SCHK: begin
        if (sts_i.c_match) begin
          state_d = S_C_SHR;
          ret_d   = RET_HIT;
        end else begin
          state_d = S_C_SRD;
        end
      end
      S_C_EV: begin
        if (sts_i.c_full) begin
          state_d = S_C_TRD;
        end else begin
          state_d = S_C_SHR;
          ret_d   = RET_INS;
        end
      end
      S_C_SHR: begin
        if (!sts_i.idx_zero) begin
          state_d = S_C_SHW;
        end else if (ret_q == RET_TAIL) begin
          state_d = S_C_TRD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_C_SHW:   state_d = S_C_SHR;
      S_C_TRD:   state_d = S_C_TGET;
      S_C_TGET:  state_d = S_T_SRD;
      S_T_SRD:   state_d = sts_i.idx_at_ct_occ ? S_C_DEC : S_T_SCHK;
      S_T_SCHK:  state_d = sts_i.ct_match_tail ? S_C_DEC : S_T_SRD;
      S_C_DEC: begin
        if (sts_i.forgive) begin
          state_d = S_C_SHR;
          ret_d   = RET_TAIL;
        end else begin
          state_d = S_C_EV;
        end
      end
      S_DONE:    if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = OP_LOAD;
      end
      S_CT_SRD:  if (!sts_i.idx_at_ct_occ) cmd_o.op = OP_CT_READ;
      S_CT_SCHK: cmd_o.op = sts_i.ct_match_key ? OP_CT_FOUND : OP_IDX_INC;
      S_CT_DROP: cmd_o.op = sts_i.ct_full ? OP_CT_DROP : OP_CT_NEW;
      S_CT_SHR:  cmd_o.op = sts_i.idx_zero ? OP_CT_HEAD : OP_CT_SH_READ;
      S_CT_SHW:  cmd_o.op = OP_CT_SH_WRITE;
      S_C_SRD:   if (!sts_i.idx_at_c_occ) cmd_o.op = OP_C_READ;
      S_C_SCHK:  cmd_o.op = sts_i.c_match ? OP_C_HIT : OP_IDX_INC;
      S_C_EV:    cmd_o.op = sts_i.c_full ? OP_LEFT_INIT : OP_C_INS_SETUP;
      S_C_SHR: begin
        if (!sts_i.idx_zero) begin
          cmd_o.op = OP_C_SH_READ;
        end else begin
          unique case (ret_q)
            RET_HIT:  cmd_o.op = OP_C_HEAD_KEY;
            RET_INS:  cmd_o.op = OP_C_HEAD_INS;
            RET_TAIL: cmd_o.op = OP_C_HEAD_TAIL;
            default:  cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_C_SHW:   cmd_o.op = OP_C_SH_WRITE;
      S_C_TRD:   cmd_o.op = OP_C_TAIL_READ;
      S_C_TGET:  cmd_o.op = OP_C_TAIL_GET;
      S_T_SRD:   cmd_o.op = sts_i.idx_at_ct_occ ? OP_T_ABSENT : OP_CT_READ;
      S_T_SCHK:  cmd_o.op = sts_i.ct_match_tail ? OP_T_FOUND : OP_IDX_INC;
      S_C_DEC:   cmd_o.op = sts_i.forgive ? OP_FORGIVE : OP_EVICT;
      S_DONE:    if (sts_i.out_free) cmd_o.op = OP_EMIT;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> hw/rtl/lcff_dp.sv
module lcff_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lcff_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lcff_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lcff_pkg::KEY_W-1:0]          in_key_i,
  input  lcff_pkg::lcff_cmd_t                 cmd_i,
  output lcff_pkg::lcff_sts_t                 sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic                                out_hit_o,
  output logic                                out_ev_valid_o,
  output logic [lcff_pkg::KEY_W-1:0]          out_ev_key_o,
  output logic [lcff_pkg::FORG_W-1:0]         out_forgiven_o,
  output logic [lcff_pkg::CNT_W-1:0]          out_count_o,
  output logic                                out_dropped_o
);
  import lcff_pkg::*;

  localparam int unsigned CT_W = KEY_W + CNT_W;

  // Configuration registers
  logic [15:0] freq_floor_q;
  logic [7:0]  forgive_lim_q;
  logic        forgive_unl_q;
  logic [8:0]  table_limit_q;
  logic [6:0]  capacity_q;

  // Control state
  logic [IDX_W-1:0]  ct_occ_q;
  logic [COCC_W-1:0] c_occ_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LEFT_W-1:0] left_q;
  logic              ct_found_q;
  logic              out_valid_q;

  // Per-item payload
  logic [KEY_W-1:0]  key_q;
  logic [KEY_W-1:0]  tail_key_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  tail_cnt_q;
  logic              hit_q;
  logic              ev_valid_q;
  logic [KEY_W-1:0]  ev_key_q;
  logic [FORG_W-1:0] forgiven_q;
  logic              dropped_q;

  // Result register
  logic              r_hit_q;
  logic              r_ev_valid_q;
  logic [KEY_W-1:0]  r_ev_key_q;
  logic [FORG_W-1:0] r_forgiven_q;
  logic [CNT_W-1:0]  r_count_q;
  logic              r_dropped_q;

  // Memories
  logic              ct_we;
  logic [CT_AW-1:0]  ct_addr;
  logic [CT_W-1:0]   ct_wdata;
  logic [CT_W-1:0]   ct_rdata;
  logic              c_we;
  logic [C_AW-1:0]   c_addr;
  logic [KEY_W-1:0]  c_wdata;
  logic [KEY_W-1:0]  c_rdata;

  logic [IDX_W-1:0]  idx_m1;
  logic [IDX_W-1:0]  eff_limit;
  logic [COCC_W-1:0] eff_cap;
  logic [KEY_W-1:0]  ct_rkey;
  logic [CNT_W-1:0]  ct_rcnt;

  assign idx_m1  = idx_q - IDX_W'(1);
  assign ct_rkey = ct_rdata[CT_W-1:CNT_W];
  assign ct_rcnt = ct_rdata[CNT_W-1:0];

  // Clamp limit and capacity into the sizes of the stores
  always_comb begin
    if (table_limit_q == '0) eff_limit = IDX_W'(1);
    else if (table_limit_q > IDX_W'(CT_DEPTH)) eff_limit = IDX_W'(CT_DEPTH);
    else eff_limit = table_limit_q;
    if (capacity_q == '0) eff_cap = COCC_W'(1);
    else if (capacity_q > COCC_W'(C_DEPTH)) eff_cap = COCC_W'(C_DEPTH);
    else eff_cap = capacity_q;
  end

  // Status to the controller
  always_comb begin
    sts_o.idx_zero      = (idx_q == '0);
    sts_o.idx_at_ct_occ = (idx_q == ct_occ_q);
    sts_o.idx_at_c_occ  = (idx_q == IDX_W'(c_occ_q));
    sts_o.ct_match_key  = (ct_rkey == key_q);
    sts_o.ct_match_tail = (ct_rkey == tail_key_q);
    sts_o.c_match       = (c_rdata == key_q);
    sts_o.ct_full       = (ct_occ_q >= eff_limit);
    sts_o.c_full        = (c_occ_q >= eff_cap);
    sts_o.forgive       = (left_q != '0) && (tail_cnt_q >= freq_floor_q);
    sts_o.out_free      = !out_valid_q || out_ready_i;
  end

  // Memory address and write selection
  always_comb begin
    ct_we    = 1'b0;
    ct_addr  = idx_q[CT_AW-1:0];
    ct_wdata = ct_rdata;
    c_we     = 1'b0;
    c_addr   = idx_q[C_AW-1:0];
    c_wdata  = c_rdata;
    case (cmd_i.op)
      OP_CT_SH_READ:  ct_addr = idx_m1[CT_AW-1:0];
      OP_CT_SH_WRITE: ct_we = 1'b1;
      OP_CT_HEAD: begin
        ct_we    = 1'b1;
        ct_addr  = '0;
        ct_wdata = {key_q, cnt_q};
      end
      OP_C_SH_READ:   c_addr = idx_m1[C_AW-1:0];
      OP_C_SH_WRITE:  c_we = 1'b1;
      OP_C_HEAD_KEY, OP_C_HEAD_INS: begin
        c_we    = 1'b1;
        c_addr  = '0;
        c_wdata = key_q;
      end
      OP_C_HEAD_TAIL: begin
        c_we    = 1'b1;
        c_addr  = '0;
        c_wdata = tail_key_q;
      end
      OP_C_TAIL_READ: c_addr = C_AW'(c_occ_q - COCC_W'(1));
      default: ;
    endcase
  end

  lcff_ram #(.WIDTH(CT_W), .DEPTH(CT_DEPTH)) u_ct_ram (
    .clk_i   (clk_i),
    .we_i    (ct_we),
    .addr_i  (ct_addr),
    .wdata_i (ct_wdata),
    .rdata_o (ct_rdata)
  );

  lcff_ram #(.WIDTH(KEY_W), .DEPTH(C_DEPTH)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .addr_i  (c_addr),
    .wdata_i (c_wdata),
    .rdata_o (c_rdata)
  );

  // Configuration and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_floor_q  <= 16'd3;
      forgive_lim_q <= 8'd5;
      forgive_unl_q <= 1'b0;
      table_limit_q <= 9'd256;
      capacity_q    <= 7'd64;
      ct_occ_q      <= '0;
      c_occ_q       <= '0;
      idx_q         <= '0;
      left_q        <= '0;
      ct_found_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (lcff_cfg_e'(cfg_idx_i))
          CFG_FREQ_FLOOR:  freq_floor_q  <= cfg_data_i;
          CFG_FORGIVE_LIM: forgive_lim_q <= cfg_data_i[7:0];
          CFG_FORGIVE_UNL: forgive_unl_q <= cfg_data_i[0];
          CFG_TABLE_LIMIT: table_limit_q <= cfg_data_i[8:0];
          CFG_CAPACITY:    capacity_q    <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      // Raise valid on a new result, drop it once the result is taken
      if (cmd_i.op == OP_EMIT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          idx_q      <= '0;
          ct_found_q <= 1'b0;
        end
        OP_IDX_INC:     idx_q <= idx_q + IDX_W'(1);
        OP_CT_FOUND:    ct_found_q <= 1'b1;
        OP_CT_DROP:     ct_occ_q <= ct_occ_q - IDX_W'(1);
        OP_CT_NEW:      idx_q <= ct_occ_q;
        OP_CT_SH_WRITE: idx_q <= idx_m1;
        OP_CT_HEAD: begin
          idx_q <= '0;
          if (!ct_found_q) ct_occ_q <= ct_occ_q + IDX_W'(1);
        end
        OP_C_INS_SETUP: idx_q <= IDX_W'(c_occ_q);
        OP_C_SH_WRITE:  idx_q <= idx_m1;
        OP_C_HEAD_INS:  c_occ_q <= c_occ_q + COCC_W'(1);
        OP_LEFT_INIT:   left_q <= forgive_unl_q ? LEFT_W'(eff_cap) : forgive_lim_q;
        OP_C_TAIL_GET:  idx_q <= '0;
        OP_FORGIVE: begin
          left_q <= left_q - LEFT_W'(1);
          idx_q  <= IDX_W'(c_occ_q - COCC_W'(1));
        end
        OP_EVICT:       c_occ_q <= c_occ_q - COCC_W'(1);
        default: ;
      endcase
    end
  end

  // Per-item payload and result register
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        key_q      <= in_key_i;
        hit_q      <= 1'b0;
        ev_valid_q <= 1'b0;
        ev_key_q   <= '0;
        forgiven_q <= '0;
        dropped_q  <= 1'b0;
      end
      OP_CT_FOUND: cnt_q <= (ct_rcnt == '1) ? ct_rcnt : ct_rcnt + CNT_W'(1);
      OP_CT_DROP:  dropped_q <= 1'b1;
      OP_CT_NEW:   cnt_q <= CNT_W'(1);
      OP_C_HIT:    hit_q <= 1'b1;
      OP_C_TAIL_GET: tail_key_q <= c_rdata;
      OP_T_ABSENT: tail_cnt_q <= '0;
      OP_T_FOUND:  tail_cnt_q <= ct_rcnt;
      OP_FORGIVE:  if (forgiven_q != '1) forgiven_q <= forgiven_q + FORG_W'(1);
      OP_EVICT: begin
        ev_valid_q <= 1'b1;
        ev_key_q   <= tail_key_q;
      end
      OP_EMIT: begin
        r_hit_q      <= hit_q;
        r_ev_valid_q <= ev_valid_q;
        r_ev_key_q   <= ev_key_q;
        r_forgiven_q <= forgiven_q;
        r_count_q    <= cnt_q;
        r_dropped_q  <= dropped_q;
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign out_hit_o      = r_hit_q;
  assign out_ev_valid_o = r_ev_valid_q;
  assign out_ev_key_o   = r_ev_key_q;
  assign out_forgiven_o = r_forgiven_q;
  assign out_count_o    = r_count_q;
  assign out_dropped_o  = r_dropped_q;

  // Occupancies never pass the store sizes
  a_ct_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ct_occ_q <= IDX_W'(CT_DEPTH))
    else $error("count table occupancy overflow");

  a_c_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_occ_q <= COCC_W'(C_DEPTH))
    else $error("cache occupancy overflow");

  // A result without eviction reports a zero key
  a_ev_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !r_ev_valid_q) |-> (r_ev_key_q == '0))
    else $error("evicted key set without eviction");

  // A hit never evicts or forgives
  a_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && r_hit_q) |-> (!r_ev_valid_q && r_forgiven_q == '0))
    else $error("hit with eviction activity");

endmodule

>>> hw/rtl/lru_cache_frequency_forgiveness.sv
// Channel | Direction | Payload
// req_i   | in        | request_key[63:0]
// rsp_o   | out       | hit, evicted_valid, evicted_key, forgiven_count, access_count,
//         |           | count_entry_dropped
// cfg     | in        | cfg_we_i, cfg_idx_i[2:0], cfg_data_i[15:0]
//
// One item at a time; each memory step is a read followed by a check or a write.
// Count table and cache are searched and shifted entry by entry, so the work for a cache
// hit grows with its position and the work for a miss grows with the cache occupancy.
// Each eviction candidate adds a search of the count table for its count and,
// when forgiven, a rotation of the cache. Reset clears occupancies, no clearing pass.
// The next item is taken once the result sits in the output register; a stalled
// result holds the block in its final state until the output register frees.
module lru_cache_frequency_forgiveness (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lcff_req_if.sink                        req_i,
  lcff_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [lcff_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lcff_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lcff_pkg::*;

  lcff_cmd_t cmd;
  lcff_sts_t sts;

  lcff_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lcff_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_key_i       (req_i.request_key),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .out_hit_o      (rsp_o.hit),
    .out_ev_valid_o (rsp_o.evicted_valid),
    .out_ev_key_o   (rsp_o.evicted_key),
    .out_forgiven_o (rsp_o.forgiven_count),
    .out_count_o    (rsp_o.access_count),
    .out_dropped_o  (rsp_o.count_entry_dropped)
  );

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lcff_pkg::*;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned CYCLE_LIMIT = 150_000_000;
  localparam logic [CNT_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic        hit;
    logic        evicted_valid;
    logic [63:0] evicted_key;
    logic [6:0]  forgiven_count;
    logic [15:0] access_count;
    logic        count_entry_dropped;
  } lookup_result_t;

  typedef struct packed {
    logic [63:0]      key;
    logic [CNT_W-1:0] count;
  } count_entry_t;

  typedef enum logic [1:0] {
    ROW_ITEM,
    ROW_TYPED,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e      kind;
    lcff_cfg_e      reg_idx;
    logic [15:0]    reg_data;
    logic [63:0]    key;
    lookup_result_t result;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lcff_req_if req ();
  lcff_rsp_if rsp ();

  lru_cache_frequency_forgiveness dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rsp_o      (rsp),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow configuration
  logic [15:0] freq_floor;
  logic [7:0]  forgive_lim;
  logic        forgive_unl;
  logic [8:0]  table_limit;
  logic [6:0]  capacity;

  // Shadow state, head of each queue is the most recent entry
  count_entry_t count_lru[$];
  logic [63:0]  cache_lru[$];

  lookup_result_t pending_results[$];
  int unsigned    error_count;
  int unsigned    cycle_count;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  logic [63:0]    key_pool[16];

  initial begin
    clk_i = 1'b0;
  end

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int find_count(input logic [63:0] key);
    for (int i = 0; i < count_lru.size(); i++) begin
      if (count_lru[i].key == key) return i;
    end
    return -1;
  endfunction

  function automatic lookup_result_t predict_lookup(input logic [63:0] key);
    lookup_result_t r;
    count_entry_t   ent;
    int             pos;
    int unsigned    tlim;
    int unsigned    cap;
    int unsigned    left;
    logic [63:0]    tail;
    logic [CNT_W-1:0] tail_cnt;
    r    = '0;
    tlim = (table_limit == 0) ? 1 : ((table_limit > CT_DEPTH) ? CT_DEPTH : table_limit);
    cap  = (capacity == 0) ? 1 : ((capacity > C_DEPTH) ? C_DEPTH : capacity);

    // Update the access counts
    pos = find_count(key);
    if (pos >= 0) begin
      ent = count_lru[pos];
      count_lru.delete(pos);
      if (ent.count != COUNT_TOP) ent.count = ent.count + 1;
    end else begin
      while (count_lru.size() >= tlim && count_lru.size() > 0) begin
        count_lru.delete(count_lru.size() - 1);
        r.count_entry_dropped = 1'b1;
      end
      ent.key   = key;
      ent.count = 1;
    end
    count_lru.insert(0, ent);
    r.access_count = ent.count[15:0];

    // Look up the cache
    pos = -1;
    for (int i = 0; i < cache_lru.size(); i++) begin
      if (cache_lru[i] == key && pos < 0) pos = i;
    end
    if (pos >= 0) begin
      r.hit = 1'b1;
      cache_lru.delete(pos);
    end else begin
      while (cache_lru.size() >= cap && cache_lru.size() > 0) begin
        left = forgive_unl ? cap : forgive_lim;
        forever begin
          tail = cache_lru[cache_lru.size() - 1];
          pos  = find_count(tail);
          tail_cnt = (pos >= 0) ? count_lru[pos].count : '0;
          if (left != 0 && tail_cnt >= freq_floor) begin
            left = left - 1;
            if (r.forgiven_count != 7'd127) r.forgiven_count = r.forgiven_count + 1;
            cache_lru.delete(cache_lru.size() - 1);
            cache_lru.insert(0, tail);
          end else begin
            cache_lru.delete(cache_lru.size() - 1);
            r.evicted_valid = 1'b1;
            r.evicted_key   = tail;
            break;
          end
        end
      end
    end
    cache_lru.insert(0, key);
    return r;
  endfunction

  // Hold until every result is in
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Write one register while the block is idle
  task automatic write_reg(input lcff_cfg_e idx, input logic [15:0] data);
    drain();
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_FREQ_FLOOR:  freq_floor  = data;
      CFG_FORGIVE_LIM: forgive_lim = data[7:0];
      CFG_FORGIVE_UNL: forgive_unl = data[0];
      CFG_TABLE_LIMIT: table_limit = data[8:0];
      CFG_CAPACITY:    capacity    = data[6:0];
      default: ;
    endcase
  endtask

  // Offer one item and record its prediction on acceptance
  task automatic send_key(input logic [63:0] key, input bit typed,
                          input lookup_result_t typed_result);
    lookup_result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.request_key <= key;
    do @(posedge clk_i); while (!req.ready);
    r = predict_lookup(key);
    pending_results.push_back(typed ? typed_result : r);
  endtask

  // Randomly stall the result side
  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each result with the oldest prediction
  always @(posedge clk_i) begin
    lookup_result_t got;
    lookup_result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = '{rsp.hit, rsp.evicted_valid, rsp.evicted_key, rsp.forgiven_count,
              rsp.access_count, rsp.count_entry_dropped};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.hit != want.hit || got.evicted_valid != want.evicted_valid ||
            got.evicted_key != want.evicted_key ||
            got.forgiven_count != want.forgiven_count ||
            got.access_count != want.access_count ||
            got.count_entry_dropped != want.count_entry_dropped) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          error_count++;
        end
      end
    end
  end

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  // Random settings for one phase
  task automatic random_config();
    logic [15:0] mf;
    logic [15:0] fl;
    logic [15:0] tl;
    logic [15:0] cp;
    mf = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(5));
    cp = 16'($urandom_range(12, 1));
    tl = 16'($urandom_range(32, 1));
    fl = ($urandom_range(7) == 0) ? 16'd255 : 16'($urandom_range(8));
    write_reg(CFG_FREQ_FLOOR, mf);
    write_reg(CFG_FORGIVE_LIM, fl);
    write_reg(CFG_FORGIVE_UNL, 16'($urandom_range(1)));
    write_reg(CFG_TABLE_LIMIT, tl);
    write_reg(CFG_CAPACITY, cp);
    for (int i = 0; i < 16; i++) key_pool[i] = rand_key();
  endtask

  stim_row_t directed_rows[] = '{
    '{ROW_TYPED, CFG_FREQ_FLOOR, 16'd0, 64'h0, '{1'b0, 1'b0, 64'h0, 7'd0, 16'd1, 1'b0}},
    '{ROW_TYPED, CFG_FREQ_FLOOR, 16'd0, 64'h0, '{1'b1, 1'b0, 64'h0, 7'd0, 16'd2, 1'b0}},
    '{ROW_TYPED, CFG_FREQ_FLOOR, 16'd0, 64'hFFFF_FFFF_FFFF_FFFF,
      '{1'b0, 1'b0, 64'h0, 7'd0, 16'd1, 1'b0}},
    '{ROW_TYPED, CFG_FREQ_FLOOR, 16'd0, 64'h5555_5555_5555_5555,
      '{1'b0, 1'b0, 64'h0, 7'd0, 16'd1, 1'b0}},
    // shrink the cache below its occupancy: two evictions on the next miss
    '{ROW_CFG, CFG_CAPACITY, 16'd2, 64'h0, '0},
    '{ROW_TYPED, CFG_FREQ_FLOOR, 16'd0, 64'hAAAA_AAAA_AAAA_AAAA,
      '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 7'd0, 16'd1, 1'b0}},
    // forgive everything, capped at the cache size
    '{ROW_CFG, CFG_FREQ_FLOOR, 16'd0, 64'h0, '0},
    '{ROW_CFG, CFG_FORGIVE_UNL, 16'd1, 64'h0, '0},
    '{ROW_CFG, CFG_CAPACITY, 16'd3, 64'h0, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h1, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h2, '0},
    // more forgives than entries: rotate past the cache size
    '{ROW_CFG, CFG_FORGIVE_UNL, 16'd0, 64'h0, '0},
    '{ROW_CFG, CFG_FORGIVE_LIM, 16'd255, 64'h0, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h3, '0},
    // zero table limit: drop all but one entry
    '{ROW_CFG, CFG_TABLE_LIMIT, 16'd0, 64'h0, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h4, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h4, '0},
    // oversize limit, zero capacity, no forgives
    '{ROW_CFG, CFG_TABLE_LIMIT, 16'd511, 64'h0, '0},
    '{ROW_CFG, CFG_CAPACITY, 16'd0, 64'h0, '0},
    '{ROW_CFG, CFG_FREQ_FLOOR, 16'hFFFF, 64'h0, '0},
    '{ROW_CFG, CFG_FORGIVE_LIM, 16'd0, 64'h0, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h5, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h6, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h6, '0},
    // oversize capacity
    '{ROW_CFG, CFG_CAPACITY, 16'd127, 64'h0, '0},
    '{ROW_CFG, CFG_FREQ_FLOOR, 16'd2, 64'h0, '0},
    '{ROW_CFG, CFG_FORGIVE_LIM, 16'd3, 64'h0, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h8000_0000_0000_0000, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h1, '0},
    '{ROW_ITEM, CFG_FREQ_FLOOR, 16'd0, 64'h7, '0}
  };

  initial begin
    lookup_result_t none;
    logic [63:0] k;
    none          = '0;
    error_count   = 0;
    cycle_count   = 0;
    send_idle_pct = 15;
    recv_idle_pct = 52;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_FREQ_FLOOR;
    cfg_data_i    = '0;
    req.valid       = 1'b0;
    req.request_key = '0;
    rsp.ready       = 1'b0;
    freq_floor  = 16'd3;
    forgive_lim = 8'd5;
    forgive_unl = 1'b0;
    table_limit = 9'd256;
    capacity    = 7'd64;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        req.valid <= 1'b0;
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_key(directed_rows[i].key, directed_rows[i].kind == ROW_TYPED,
                 directed_rows[i].result);
      end
    end

    // Random phases: mostly keys from a small pool so that hits and forgives occur
    for (int phase = 0; phase < 7; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 52;
        recv_idle_pct = 15;
      end else if (phase == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      req.valid <= 1'b0;
      random_config();
      for (int n = 0; n < 150; n++) begin
        if (phase == 1 && n == 75) begin
          req.valid <= 1'b0;
          drain();
          @(posedge clk_i);
        end
        k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(15)] : rand_key();
        send_key(k, 1'b0, none);
      end
    end

    req.valid <= 1'b0;
    drain();
    repeat (200) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> lru_cache_frequency_forgiveness.f
hw/rtl/lcff_pkg.sv
hw/rtl/lcff_if.sv
hw/rtl/lcff_ram.sv
hw/rtl/lcff_ctrl.sv
hw/rtl/lcff_dp.sv
hw/rtl/lru_cache_frequency_forgiveness.sv
tb/sv/tb_top.sv
